[rtl/pmd_pkg.sv]
// Package for the PID motor drive step: fixed field widths, register
// indexes and the control bundle passed down the multiply/saturate pipe.
// No dependencies.
package pmd_pkg;

  // Gain registers: unsigned Q4.12
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;

  // Result fields
  localparam int DUTY_W    = 8;
  localparam int ERR_OUT_W = 11;
  localparam int OUT_W     = 24;  // 1 + 8 + 11 bits, padded to bytes

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

  // Per-item control that rides along with the operands
  typedef struct packed {
    logic                 valid;
    logic                 fwd;
    logic [ERR_OUT_W-1:0] err_now;
  } pmd_ctl_t;

endpackage

[rtl/pmd_mac.sv]
// Gain multiply, three-term sum and duty saturation for the PID step.
// One register stage: the result register. Uses pmd_pkg.
module pmd_mac import pmd_pkg::*; #(
  parameter int OPE_W = 12,
  parameter int OPS_W = 11,
  parameter int OPD_W = 13
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  pmd_ctl_t                in_ctl,
  input  logic signed [OPE_W-1:0] op_err,
  input  logic signed [OPS_W-1:0] op_sum,
  input  logic signed [OPD_W-1:0] op_der,
  input  logic [GAIN_W-1:0]       prop_gain,
  input  logic [GAIN_W-1:0]       integ_gain,
  input  logic [GAIN_W-1:0]       deriv_gain,
  output pmd_ctl_t                out_ctl,
  output logic [DUTY_W-1:0]       duty
);

  localparam int PE_W  = GAIN_W + 1 + OPE_W;
  localparam int PS_W  = GAIN_W + 1 + OPS_W;
  localparam int PD_W  = GAIN_W + 1 + OPD_W;
  localparam int PM_W  = (PE_W > PS_W) ? ((PE_W > PD_W) ? PE_W : PD_W)
                                       : ((PS_W > PD_W) ? PS_W : PD_W);
  localparam int ACC_W = PM_W + 2;
  localparam int TOP_B = GAIN_FRAC + DUTY_W;

  logic signed [PE_W-1:0]  prod_e;
  logic signed [PS_W-1:0]  prod_s;
  logic signed [PD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0] acc;
  logic [DUTY_W-1:0]       duty_next;

  // Three independent multiplies, gains taken as non-negative
  assign prod_e = $signed({1'b0, prop_gain})  * op_err;
  assign prod_s = $signed({1'b0, integ_gain}) * op_sum;
  assign prod_d = $signed({1'b0, deriv_gain}) * op_der;

  // Sum (already oriented), then floor to zero and saturate at full duty
  assign acc = ACC_W'(prod_e) + ACC_W'(prod_s) + ACC_W'(prod_d);

  always_comb begin
    if (acc[ACC_W-1] || (acc == '0)) begin
      duty_next = '0;
    end else if (|acc[ACC_W-2:TOP_B]) begin
      duty_next = '1;
    end else begin
      duty_next = acc[TOP_B-1:GAIN_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else if (advance) begin
      out_ctl.valid <= in_ctl.valid;
    end
    if (advance) begin
      out_ctl.fwd     <= in_ctl.fwd;
      out_ctl.err_now <= in_ctl.err_now;
      duty            <= duty_next;
    end
  end

endmodule

[rtl/pid_motor_drive_step.sv]
// PID motor drive step: error, clamped integral and derivative, then
// Q4.12 gain sum saturated to a PWM duty. Uses pmd_pkg and pmd_mac.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid / s_tready  target_value, measured_value
//   m_*       out  m_tvalid / m_tready  drive_forward, duty_cycle, error_now
//   cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (gain writes)
//
// One sample is taken per cycle while the result register is free or being
// drained; the operand register loads at the transfer, then the result register as the pipe advances.
// Reset clears the gains, the error accumulator and the last error.
// While a result waits on m_tready the whole pipe holds and s_tready drops.
// Gain writes are always ready.
module pid_motor_drive_step import pmd_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int SUM_LIMIT   = 500
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [SAMPLE_BITS-1:0] target_value, [2*SAMPLE_BITS-1:SAMPLE_BITS] measured_value
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] drive_forward, [8:1] duty_cycle, [19:9] error_now, [23:20] zero
  output logic [OUT_W-1:0]                     m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [GAIN_W-1:0]                    cfg_data
);

  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int LIM_W  = $clog2(SUM_LIMIT + 1) + 1;
  localparam int SUMR_W = ((ERR_W > LIM_W) ? ERR_W : LIM_W) + 1;
  localparam int DER_W  = ERR_W + 1;
  localparam int OPE_W  = ERR_W + 1;
  localparam int OPS_W  = LIM_W + 1;
  localparam int OPD_W  = DER_W + 1;
  localparam int EXT_W  = (ERR_W > ERR_OUT_W) ? ERR_W : ERR_OUT_W;
  localparam logic signed [SUMR_W-1:0] LIM_POS = SUMR_W'(SUM_LIMIT);
  localparam logic signed [SUMR_W-1:0] LIM_NEG = -LIM_POS;

  logic [GAIN_W-1:0]        prop_gain;
  logic [GAIN_W-1:0]        integ_gain;
  logic [GAIN_W-1:0]        deriv_gain;
  logic signed [LIM_W-1:0]  error_sum, error_sum_next;
  logic signed [ERR_W-1:0]  last_error;

  logic                     advance;
  logic                     accept;
  logic [SAMPLE_BITS-1:0]   target_value;
  logic [SAMPLE_BITS-1:0]   measured_value;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUMR_W-1:0] sum_raw;
  logic signed [DER_W-1:0]  deriv;
  logic signed [EXT_W-1:0]  err_ext;
  logic                     fwd;

  pmd_ctl_t                 op_ctl, op_ctl_next, res_ctl;
  logic signed [OPE_W-1:0]  op_err, op_err_next;
  logic signed [OPS_W-1:0]  op_sum, op_sum_next;
  logic signed [OPD_W-1:0]  op_der, op_der_next;
  logic [DUTY_W-1:0]        duty;

  // Pipe moves whenever the result register is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  // Gain registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  assign target_value   = s_tdata[SAMPLE_BITS-1:0];
  assign measured_value = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // Error, clamped integral, derivative
  assign err     = $signed({1'b0, target_value}) - $signed({1'b0, measured_value});
  assign sum_raw = SUMR_W'(error_sum) + SUMR_W'(err);
  assign deriv   = DER_W'(err) - DER_W'(last_error);
  assign err_ext = EXT_W'(err);
  assign fwd     = !err[ERR_W-1] && (err != '0);

  always_comb begin
    if (sum_raw > LIM_POS) begin
      error_sum_next = LIM_W'(LIM_POS);
    end else if (sum_raw < LIM_NEG) begin
      error_sum_next = LIM_W'(LIM_NEG);
    end else begin
      error_sum_next = LIM_W'(sum_raw);
    end
  end

  // Orient operands: reverse drive negates the whole sum
  assign op_err_next = fwd ? OPE_W'(err)            : -(OPE_W'(err));
  assign op_sum_next = fwd ? OPS_W'(error_sum_next) : -(OPS_W'(error_sum_next));
  assign op_der_next = fwd ? OPD_W'(deriv)          : -(OPD_W'(deriv));

  assign op_ctl_next.valid   = s_tvalid;
  assign op_ctl_next.fwd     = fwd;
  assign op_ctl_next.err_now = err_ext[ERR_OUT_W-1:0];

  // Loop state, updated once per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (accept) begin
      error_sum  <= error_sum_next;
      last_error <= err;
    end
  end

  // Operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_ctl.valid <= 1'b0;
    end else if (advance) begin
      op_ctl.valid <= op_ctl_next.valid;
    end
    if (accept) begin
      op_ctl.fwd     <= op_ctl_next.fwd;
      op_ctl.err_now <= op_ctl_next.err_now;
      op_err         <= op_err_next;
      op_sum         <= op_sum_next;
      op_der         <= op_der_next;
    end
  end

  pmd_mac #(
    .OPE_W (OPE_W),
    .OPS_W (OPS_W),
    .OPD_W (OPD_W)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_ctl     (op_ctl),
    .op_err     (op_err),
    .op_sum     (op_sum),
    .op_der     (op_der),
    .prop_gain  (prop_gain),
    .integ_gain (integ_gain),
    .deriv_gain (deriv_gain),
    .out_ctl    (res_ctl),
    .duty       (duty)
  );

  assign m_tvalid = res_ctl.valid;
  assign m_tdata  = {{(OUT_W - 1 - DUTY_W - ERR_OUT_W){1'b0}},
                     res_ctl.err_now, duty, res_ctl.fwd};

`ifndef SYNTHESIS
  // Integral never leaves its clamp window
  a_sum_window: assert property (@(posedge clk) disable iff (rst)
    (LIM_W'(LIM_NEG) <= error_sum) && (error_sum <= LIM_W'(LIM_POS)))
    else $error("error_sum outside clamp window");

  // A held result blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("sample taken while result stalled");

  // Loop state moves only with a transfer
  a_state_hold: assert property (@(posedge clk)
    (!rst && !accept) |=> ($stable(last_error) && $stable(error_sum)))
    else $error("loop state changed without a transfer");

  // A transferred sample enters the operand stage
  a_op_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> op_ctl.valid)
    else $error("transfer lost before operand stage");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking bench for pid_motor_drive_step: drives setpoint/feedback samples and
// gain writes, predicts direction, duty and error per sample, checks each result.
// Depends on rtl/pmd_pkg.sv and rtl/pid_motor_drive_step.sv.
module tb import pmd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = 10;
  localparam int SUM_LIMIT  = 500;
  localparam int S_W        = ((2*SAMPLE_W+7)/8)*8;
  localparam int DUTY_TOP   = 255;
  localparam int GAIN_TOP   = 40960;
  localparam int SAMPLE_TOP = 1023;
  localparam int PHASE_LEN  = 225;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] target;
    logic [SAMPLE_W-1:0] measured;
  } sample_t;

  typedef struct packed {
    logic                 fwd;
    logic [DUTY_W-1:0]    duty;
    logic [ERR_OUT_W-1:0] err;
  } drive_result_t;

  typedef enum int {
    RUN_UNIFORM, RUN_NEAR, RUN_PUSH_UP, RUN_PUSH_DOWN, RUN_EQUAL
  } run_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  // Predictor copy of the gains and the controller state
  logic [GAIN_W-1:0]    kp_gain = '0;
  logic [GAIN_W-1:0]    ki_gain = '0;
  logic [GAIN_W-1:0]    kd_gain = '0;
  logic [ERR_OUT_W-1:0] error_sum = '0;
  logic [ERR_OUT_W-1:0] last_error = '0;

  sample_t       sample_queue[$];
  drive_result_t drive_expect_q[$];
  int            samples_pending = 0;
  int            mismatch_count = 0;
  int            idle_odds = 0;  // 0: no idling on either side

  sample_t cur_sample;
  int      send_gap = 0;
  int      stall_gap = 0;
  int      quiet_cycles = 0;

  always #5 clk = ~clk;

  pid_motor_drive_step #(
    .SAMPLE_BITS(SAMPLE_W),
    .SUM_LIMIT  (SUM_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // One controller step: error, clamped integral, slope, gain sum, duty
  function automatic drive_result_t predict_drive(input sample_t smp);
    logic signed [11:0] err_v;
    logic signed [11:0] sum_v;
    logic signed [11:0] slope_v;
    logic signed [39:0] acc_v;
    drive_result_t      res;
    err_v = $signed({2'b00, smp.target}) - $signed({2'b00, smp.measured});
    sum_v = $signed({error_sum[ERR_OUT_W-1], error_sum}) + err_v;
    if (sum_v > SUM_LIMIT) sum_v = 12'(SUM_LIMIT);
    if (sum_v < -SUM_LIMIT) sum_v = 12'(-SUM_LIMIT);
    slope_v = err_v - $signed({last_error[ERR_OUT_W-1], last_error});
    acc_v = $signed({24'd0, kp_gain}) * err_v
          + $signed({24'd0, ki_gain}) * sum_v
          + $signed({24'd0, kd_gain}) * slope_v;
    res.fwd = (err_v > 0);
    // zero error drives reverse, same as negative
    if (!res.fwd) acc_v = -acc_v;
    if (acc_v <= 0) begin
      res.duty = '0;
    end else if ((acc_v >>> GAIN_FRAC) > DUTY_TOP) begin
      res.duty = DUTY_W'(DUTY_TOP);
    end else begin
      res.duty = acc_v[GAIN_FRAC +: DUTY_W];
    end
    res.err = err_v[ERR_OUT_W-1:0];
    error_sum = sum_v[ERR_OUT_W-1:0];
    last_error = err_v[ERR_OUT_W-1:0];
    return res;
  endfunction

  // Sample driver: record the transfer, then load the next item or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        drive_expect_q.push_back(predict_drive(cur_sample));
        samples_pending--;
      end
      if (!s_tvalid || s_tready) begin
        if (idle_odds != 0 && send_gap == 0 && $urandom_range(0, idle_odds - 1) == 0)
          send_gap = $urandom_range(1, 11);
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          cur_sample = sample_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= S_W'({cur_sample.measured, cur_sample.target});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest prediction
  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_expect_q.size() == 0) begin
          $error("unexpected result transfer, tdata %h", m_tdata);
          mismatch_count++;
        end else begin
          want = drive_expect_q.pop_front();
          if (m_tdata[0] !== want.fwd) begin
            $error("drive_forward: expected %0d, got %0d", want.fwd, m_tdata[0]);
            mismatch_count++;
          end
          if (m_tdata[8:1] !== want.duty) begin
            $error("duty_cycle: expected %0d, got %0d", want.duty, m_tdata[8:1]);
            mismatch_count++;
          end
          if (m_tdata[19:9] !== want.err) begin
            $error("error_now: expected %0d, got %0d",
                   $signed(want.err), $signed(m_tdata[19:9]));
            mismatch_count++;
          end
        end
      end
      if (idle_odds != 0 && stall_gap == 0 && $urandom_range(0, idle_odds - 1) == 0)
        stall_gap = $urandom_range(1, 11);
      if (stall_gap > 0) begin
        stall_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Gain write; only called with the pipe empty
  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PROP_GAIN:  kp_gain = value;
      REG_INTEG_GAIN: ki_gain = value;
      REG_DERIV_GAIN: kd_gain = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd);
    write_gain(REG_PROP_GAIN, kp);
    write_gain(REG_INTEG_GAIN, ki);
    write_gain(REG_DERIV_GAIN, kd);
  endtask

  task automatic queue_sample(input int target, input int measured);
    sample_t smp;
    smp.target = SAMPLE_W'(target);
    smp.measured = SAMPLE_W'(measured);
    samples_pending++;
    sample_queue.push_back(smp);
  endtask

  // Sender holds off until every result of the phase is back
  task automatic wait_drained();
    while (samples_pending != 0 || drive_expect_q.size() != 0) @(posedge clk);
  endtask

  // Runs of one character so the integral reaches its clamps and sits near zero
  task automatic queue_random_phase(input int count);
    run_kind_t kind;
    int        run_len;
    int        tgt;
    int        meas;
    int        made;
    made = 0;
    while (made < count) begin
      kind = run_kind_t'($urandom_range(0, 4));
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        tgt = $urandom_range(0, SAMPLE_TOP);
        case (kind)
          RUN_UNIFORM:   meas = $urandom_range(0, SAMPLE_TOP);
          RUN_NEAR:      meas = tgt + $urandom_range(0, 40) - 20;
          RUN_PUSH_UP:   meas = tgt - $urandom_range(0, 300);
          RUN_PUSH_DOWN: meas = tgt + $urandom_range(0, 300);
          default:       meas = tgt;
        endcase
        if (meas < 0) meas = 0;
        if (meas > SAMPLE_TOP) meas = SAMPLE_TOP;
        if (made < count) queue_sample(tgt, meas);
        made++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    kp_gain = '0;
    ki_gain = '0;
    kd_gain = '0;
    error_sum = '0;
    last_error = '0;

    // Directed: unity-ish gains, field extremes, zero error, both integral clamps
    idle_odds = 5;
    set_gains(16'd4096, 16'd2048, 16'd1024);
    write_gain(REG_UNUSED, 16'($urandom));
    queue_sample(0, 0);
    queue_sample(SAMPLE_TOP, 0);
    queue_sample(SAMPLE_TOP, 0);
    queue_sample(0, SAMPLE_TOP);
    queue_sample(0, SAMPLE_TOP);
    queue_sample(0, SAMPLE_TOP);
    queue_sample(SAMPLE_TOP, SAMPLE_TOP);
    queue_sample(512, 511);
    queue_sample(511, 512);
    queue_sample(SAMPLE_TOP, 0);
    queue_sample(SAMPLE_TOP, 0);
    queue_sample(SAMPLE_TOP, 0);
    queue_sample(0, SAMPLE_TOP);
    queue_sample(700, 700);
    queue_sample(1, 0);
    queue_sample(0, 1);
    queue_sample(SAMPLE_TOP, SAMPLE_TOP - 1);
    queue_sample(341, 682);
    queue_sample(682, 341);
    wait_drained();

    // Random phases over several gain settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          idle_odds = 4;
          set_gains(16'd0, 16'd0, 16'd0);
        end
        1: begin
          idle_odds = 12;
          set_gains(16'(GAIN_TOP), 16'(GAIN_TOP), 16'(GAIN_TOP));
        end
        2: begin
          // gains above 10.0 are taken as written
          idle_odds = 3;
          set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        end
        3: begin
          idle_odds = 6;
          set_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                    16'($urandom_range(0, 1024)));
          write_gain(REG_UNUSED, 16'($urandom));
        end
        4: begin
          idle_odds = 20;
          set_gains(16'($urandom_range(0, GAIN_TOP)), 16'($urandom_range(0, GAIN_TOP)),
                    16'($urandom_range(0, GAIN_TOP)));
        end
        default: begin
          // closing stretch runs back to back
          idle_odds = 0;
          set_gains(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                    16'($urandom_range(0, 512)));
        end
      endcase
      queue_random_phase(PHASE_LEN);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (drive_expect_q.size() != 0) begin
      $error("%0d predicted results never arrived", drive_expect_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[pid_motor_drive_step.f]
rtl/pmd_pkg.sv
rtl/pmd_mac.sv
rtl/pid_motor_drive_step.sv
tb/sv/tb.sv
